// ----- sv/gradient_magnitude_2x2_assert.svh -----
`ifndef GRADIENT_MAGNITUDE_2X2_ASSERT_SVH
`define GRADIENT_MAGNITUDE_2X2_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define GM2X2_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define GM2X2_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- sv/gm2x2_pkg.sv -----
package gm2x2_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CNT_W     = COL_W + 1;
   localparam int CFG_W     = 12;
   localparam int ROW_W     = 12;
   localparam int PIX_W     = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
   localparam logic [PIX_W-1:0] EDGE_SAT         = 8'd255;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

   localparam int ROOT_STEPS = 8;
   localparam int STEP_W     = $clog2(ROOT_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH,
      CSR_FRAME_HEIGHT
   } gm2x2_csr_idx_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SUM,
      BK_ROOT,
      BK_HOLD
   } gm2x2_bk_state_type;

   // one pixel after classification, with the pixel above it
   typedef struct packed {
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] pixel;
      logic             emit;
      logic             row_end;
      logic             frame_end;
   } gm2x2_item_type;

   typedef struct packed {
      logic [Q_LVL_W-1:0] level;
      logic               nonempty;
   } gm2x2_qstat_type;

endpackage

// ----- sv/gm2x2_ifs.sv -----
interface gm2x2_req_if;
   import gm2x2_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             frame_start;
   modport source (output valid, pixel, frame_start, input ready);
   modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface gm2x2_rsp_if;
   import gm2x2_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] edge_res;
   logic             row_end;
   logic             frame_end;
   modport source (output valid, edge_res, row_end, frame_end, input ready);
   modport sink (input valid, edge_res, row_end, frame_end, output ready);
endinterface

interface gm2x2_csr_if;
   import gm2x2_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/gm2x2_ram.sv -----
module gm2x2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write at one address return the old word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gm2x2_front.sv -----
`include "gradient_magnitude_2x2_assert.svh"

module gm2x2_front (
   input  logic                       clock,
   input  logic                       reset,
   gm2x2_req_if.sink                  req,
   gm2x2_csr_if.sink                  csr,
   input  gm2x2_pkg::gm2x2_qstat_type q_stat,
   output logic                       push,
   output gm2x2_pkg::gm2x2_item_type  push_item
);
   import gm2x2_pkg::*;

   logic [CFG_W-1:0] line_width_ff, line_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic             s1_emit_ff;
   logic             s1_re_ff;
   logic             s1_fe_ff;

   logic [CNT_W-1:0]   w_use;
   logic [ROW_W-1:0]   h_use;
   logic               accept;
   logic [COL_W-1:0]   col_a, col_b;
   logic [ROW_W-1:0]   row_a, row_c, row_nw;
   logic [ROW_W:0]     row_bx, row_nx;
   logic [CNT_W-1:0]   col_nx;
   logic               wrap_a, wrap_n;
   logic               emit, re, fe;
   logic [Q_LVL_W:0]   in_flight;
   logic [PIX_W-1:0]   above;

   // width clamped to [2, MAX_WIDTH], height to at least 2
   always_comb begin
      if (line_width_ff < CFG_W'(2)) begin
         w_use = CNT_W'(2);
      end else if (line_width_ff > CFG_W'(MAX_WIDTH)) begin
         w_use = CNT_W'(MAX_WIDTH);
      end else begin
         w_use = CNT_W'(line_width_ff);
      end
      h_use = (frame_height_ff < CFG_W'(2)) ? ROW_W'(2) : frame_height_ff;
   end

   assign in_flight = {1'b0, q_stat.level} + (Q_LVL_W+1)'(s1_valid_ff);
   assign req.ready = in_flight < (Q_LVL_W+1)'(Q_DEPTH);
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // position of this beat, then position of the next one
   always_comb begin
      col_a  = req.frame_start ? '0 : col_ff;
      row_a  = req.frame_start ? '0 : row_ff;
      wrap_a = {1'b0, col_a} >= w_use;
      col_b  = wrap_a ? '0 : col_a;
      row_bx = wrap_a ? {1'b0, row_a} + (ROW_W+1)'(1) : {1'b0, row_a};
      row_c  = (row_bx >= {1'b0, h_use}) ? '0 : row_bx[ROW_W-1:0];

      emit = (row_c != '0) && (col_b != '0);
      re   = {1'b0, col_b} == (w_use - CNT_W'(1));
      fe   = re && (row_c == (h_use - ROW_W'(1)));

      col_nx = {1'b0, col_b} + CNT_W'(1);
      wrap_n = col_nx >= w_use;
      row_nx = {1'b0, row_c} + (ROW_W+1)'(1);
      row_nw = (row_nx >= {1'b0, h_use}) ? '0 : row_nx[ROW_W-1:0];

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = wrap_n ? '0 : col_nx[COL_W-1:0];
         row_in = wrap_n ? row_nw : row_c;
      end
   end

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_LINE_WIDTH:   line_width_in   = csr.data;
            CSR_FRAME_HEIGHT: frame_height_in = csr.data;
            default: ;
         endcase
      end
   end

   assign s1_valid_in = accept;

   gm2x2_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_b),
      .wr_data (req.pixel),
      .rd_en   (accept),
      .rd_addr (col_b),
      .rd_data (above)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req.pixel;
         s1_emit_ff  <= emit;
         s1_re_ff    <= re;
         s1_fe_ff    <= fe;
      end
   end

   // line store data lands in the cycle after the beat
   assign push                = s1_valid_ff;
   assign push_item.above     = above;
   assign push_item.pixel     = s1_pixel_ff;
   assign push_item.emit      = s1_emit_ff;
   assign push_item.row_end   = s1_re_ff;
   assign push_item.frame_end = s1_fe_ff;

   `GM2X2_ASSERT(a_push_room, s1_valid_ff |-> (q_stat.level < Q_LVL_W'(Q_DEPTH)), "queue full at push")
   `GM2X2_ASSERT(a_col_bound, {1'b0, col_ff} < CNT_W'(MAX_WIDTH) || !accept, "column out of range")
   `GM2X2_ASSERT(a_fe_has_re, (accept && fe) |-> (re && emit), "frame end without row end")

endmodule

// ----- sv/gm2x2_queue.sv -----
`include "gradient_magnitude_2x2_assert.svh"

module gm2x2_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gm2x2_pkg::gm2x2_item_type  push_item,
   input  logic                       pop,
   output gm2x2_pkg::gm2x2_item_type  pop_item,
   output gm2x2_pkg::gm2x2_qstat_type q_stat
);
   import gm2x2_pkg::*;

   gm2x2_item_type     entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_LVL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + Q_LVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - Q_LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item        = entry_ff[rd_ptr_ff];
   assign q_stat.level    = level_ff;
   assign q_stat.nonempty = level_ff != '0;

   `GM2X2_NEVER(a_q_overflow, push && !pop && (level_ff == Q_LVL_W'(Q_DEPTH)), "queue overflow")
   `GM2X2_NEVER(a_q_underflow, pop && (level_ff == '0), "queue underflow")
   `GM2X2_ASSERT(a_q_ptrs, (level_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff), "pointers apart when empty")

endmodule

// ----- sv/gm2x2_back.sv -----
`include "gradient_magnitude_2x2_assert.svh"

module gm2x2_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gm2x2_pkg::gm2x2_qstat_type q_stat,
   input  gm2x2_pkg::gm2x2_item_type  pop_item,
   output logic                       pop,
   gm2x2_rsp_if.source                rsp
);
   import gm2x2_pkg::*;

   gm2x2_bk_state_type state_ff, state_in;

   logic [PIX_W-1:0]  left_cur_ff, left_prev_ff;
   logic signed [9:0] gx_ff, gy_ff;
   logic              re_ff, fe_ff;
   logic [15:0]       rad_ff, rad_in;
   logic [10:0]       rem_ff, rem_in;
   logic [7:0]        root_ff, root_in;
   logic              sat_ff;
   logic [STEP_W-1:0] step_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  edge_ff;
   logic              rsp_re_ff, rsp_fe_ff;

   logic              load;
   logic [8:0]        sum_ac, sum_bd, sum_ab, sum_cd;
   logic signed [9:0] gx, gy;
   logic signed [19:0] gx2, gy2;
   logic [19:0]       mag2;
   logic [10:0]       rem_sh, trial;
   logic              take;
   logic              last_step;

   // window: a above-left, b above, c left, d current
   always_comb begin
      sum_ac = {1'b0, left_prev_ff} + {1'b0, left_cur_ff};
      sum_bd = {1'b0, pop_item.above} + {1'b0, pop_item.pixel};
      sum_ab = {1'b0, left_prev_ff} + {1'b0, pop_item.above};
      sum_cd = {1'b0, left_cur_ff} + {1'b0, pop_item.pixel};
      gx     = $signed({1'b0, sum_bd}) - $signed({1'b0, sum_ac});
      gy     = $signed({1'b0, sum_cd}) - $signed({1'b0, sum_ab});
   end

   always_comb begin
      gx2  = gx_ff * gx_ff;
      gy2  = gy_ff * gy_ff;
      mag2 = $unsigned(gx2) + $unsigned(gy2);
   end

   // one root bit per step, two radicand bits in
   always_comb begin
      rem_sh  = {rem_ff[8:0], rad_ff[15:14]};
      trial   = {1'b0, root_ff, 2'b01};
      take    = rem_sh >= trial;
      rem_in  = take ? rem_sh - trial : rem_sh;
      root_in = {root_ff[6:0], take};
      rad_in  = {rad_ff[13:0], 2'b00};
   end

   assign last_step = step_ff == STEP_W'(ROOT_STEPS - 1);

   always_comb begin
      pop  = (state_ff == BK_IDLE) && q_stat.nonempty;
      load = (state_ff == BK_HOLD) && (!rsp_valid_ff || rsp.ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_stat.nonempty && pop_item.emit) begin
               state_in = BK_SUM;
            end
         end
         BK_SUM:  state_in = BK_ROOT;
         BK_ROOT: begin
            if (last_step) begin
               state_in = BK_HOLD;
            end
         end
         BK_HOLD: begin
            if (load) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         left_cur_ff  <= '0;
         left_prev_ff <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            left_prev_ff <= pop_item.above;
            left_cur_ff  <= pop_item.pixel;
         end
         if (state_ff == BK_SUM) begin
            step_ff <= '0;
         end else if (state_ff == BK_ROOT) begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         gx_ff <= gx;
         gy_ff <= gy;
         re_ff <= pop_item.row_end;
         fe_ff <= pop_item.frame_end;
      end
      if (state_ff == BK_SUM) begin
         rad_ff  <= mag2[15:0];
         sat_ff  <= |mag2[19:16];
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (state_ff == BK_ROOT) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (load) begin
         edge_ff   <= sat_ff ? EDGE_SAT : root_ff;
         rsp_re_ff <= re_ff;
         rsp_fe_ff <= fe_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.edge_res  = edge_ff;
   assign rsp.row_end   = rsp_re_ff;
   assign rsp.frame_end = rsp_fe_ff;

   `GM2X2_ASSERT(a_sum_to_root, (state_ff == BK_SUM) |=> (state_ff == BK_ROOT && step_ff == '0), "root did not start")
   `GM2X2_NEVER(a_pop_busy, pop && (state_ff != BK_IDLE), "pop while busy")
   `GM2X2_ASSERT(a_load_sets, load |=> rsp_valid_ff, "result lost at load")

endmodule

// ----- sv/gradient_magnitude_2x2.sv -----
// 2x2 gradient-magnitude edge detector. Pixels arrive in raster order on req_chan, one 8-bit
// grayscale value per beat, with frame_start marking pixel (0,0). For each pixel (y+1,x+1) the
// block forms the window (y,x) (y,x+1) (y+1,x) (y+1,x+1), takes Gx and Gy as column and row
// sums of differences and returns floor(sqrt(Gx^2+Gy^2)) clamped to 255 on rsp_chan for
// position (y,x); the last row and last column give no beat. row_end flags column
// line_width-2, frame_end the last result of the frame. line_width (index 0, clamped to
// 2..2048) and frame_height (index 1, at least 2) are to be written on csr_chan while idle;
// the block itself does not enforce this. The front end takes one pixel per clock as long
// as its 4-entry queue has room, reading and writing the 2048x8 line store in that cycle;
// the store needs no clearing pass. The back end pops a pixel with no result and drops it;
// a pixel with a result goes through pop, sum of squares, eight root steps and hand-off to
// the output register before the next pop, so the square-root unit sets the pace in a frame.
module gradient_magnitude_2x2 (
   input logic          clock,
   input logic          reset,
   gm2x2_req_if.sink    req_chan,
   gm2x2_rsp_if.source  rsp_chan,
   gm2x2_csr_if.sink    csr_chan
);
   import gm2x2_pkg::*;

   gm2x2_qstat_type q_stat;
   gm2x2_item_type  push_item;
   gm2x2_item_type  pop_item;
   logic            push;
   logic            pop;

   gm2x2_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr       (csr_chan),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   gm2x2_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   gm2x2_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

// ----- dv/tb_gradient_magnitude_2x2.sv -----
module tb_gradient_magnitude_2x2;
   import gm2x2_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic             row_end;
      logic             frame_end;
   } edge_beat_type;

   class edge_scoreboard_type;
      logic [CFG_W-1:0] line_width;
      logic [CFG_W-1:0] frame_height;
      logic [PIX_W-1:0] row_above [MAX_WIDTH];
      bit               filled [MAX_WIDTH];
      logic [PIX_W-1:0] left_now;
      logic [PIX_W-1:0] left_above;
      int               col;
      int               row;
      edge_beat_type    pending_edges [$];
      int               mismatches;

      function new();
         line_width   = LINE_WIDTH_RST;
         frame_height = FRAME_HEIGHT_RST;
         left_now     = '0;
         left_above   = '0;
         col          = 0;
         row          = 0;
         mismatches   = 0;
         foreach (row_above[i]) begin
            row_above[i] = '0;
            filled[i]    = 1'b0;
         end
      endfunction

      function int cols_in_use();
         if (line_width < 2) return 2;
         if (line_width > MAX_WIDTH) return MAX_WIDTH;
         return int'(line_width);
      endfunction

      function int rows_in_use();
         if (frame_height < 2) return 2;
         return int'(frame_height);
      endfunction

      function void write_register(gm2x2_csr_idx_type idx, logic [CFG_W-1:0] value);
         if (idx == CSR_LINE_WIDTH) line_width = value;
         else frame_height = value;
      endfunction

      // next beat without a frame start would land below the first row on a column
      // the line store has never seen
      function bit needs_restart();
         int c;
         int r;
         c = col;
         r = row;
         if (c >= cols_in_use()) begin
            c = 0;
            r++;
         end
         if (r >= rows_in_use()) r = 0;
         return r >= 1 && !filled[c];
      endfunction

      function void note_pixel(logic [PIX_W-1:0] pixel, logic frame_start);
         int               w;
         int               h;
         int               gx;
         int               gy;
         int unsigned      sum;
         int unsigned      root;
         int unsigned      trial;
         logic [PIX_W-1:0] above;
         edge_beat_type    beat;
         w = cols_in_use();
         h = rows_in_use();
         if (frame_start) begin
            col = 0;
            row = 0;
         end
         // geometry may have shrunk under the counts
         if (col >= w) begin
            col = 0;
            row++;
         end
         if (row >= h) row = 0;
         above = row_above[col];
         if (row >= 1 && col >= 1) begin
            gx   = (int'(above) + int'(pixel)) - (int'(left_above) + int'(left_now));
            gy   = (int'(left_now) + int'(pixel)) - (int'(left_above) + int'(above));
            sum  = gx * gx + gy * gy;
            root = 0;
            for (int b = 15; b >= 0; b--) begin
               trial = root | (32'd1 << b);
               if (trial * trial <= sum) root = trial;
            end
            beat.magnitude = (root > 255) ? EDGE_SAT : root[PIX_W-1:0];
            beat.row_end   = (col == w - 1);
            beat.frame_end = beat.row_end && (row == h - 1);
            pending_edges = {pending_edges, beat};
         end
         row_above[col] = pixel;
         filled[col]    = 1'b1;
         left_above     = above;
         left_now       = pixel;
         col++;
         if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
         end
      endfunction

      task report(string msg);
         if (mismatches < 100) $display("edge check: %s", msg);
         mismatches++;
      endtask

      task check_edge(logic [PIX_W-1:0] magnitude, logic row_end, logic frame_end);
         edge_beat_type want;
         if (pending_edges.size() == 0) begin
            report($sformatf("edge beat %0d arrived with nothing pending", magnitude));
            return;
         end
         want = pending_edges.pop_front();
         if (magnitude !== want.magnitude)
            report($sformatf("magnitude %0d, want %0d", magnitude, want.magnitude));
         if (row_end !== want.row_end)
            report($sformatf("row_end %b, want %b", row_end, want.row_end));
         if (frame_end !== want.frame_end)
            report($sformatf("frame_end %b, want %b", frame_end, want.frame_end));
      endtask
   endclass

   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PIXELS = 900;
   localparam int CALM_FROM     = 700;

   logic clock;
   logic reset;

   gm2x2_req_if req_chan ();
   gm2x2_rsp_if rsp_chan ();
   gm2x2_csr_if csr_chan ();

   gradient_magnitude_2x2 i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   edge_scoreboard_type edges;
   bit                  calm;
   int                  stall_left = 0;
   int unsigned         cycles = 0;
   logic [PIX_W-1:0]    last_pixel;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         edges.check_edge(rsp_chan.edge_res, rsp_chan.row_end, rsp_chan.frame_end);

   function automatic logic [PIX_W-1:0] next_pixel();
      int v;
      case ($urandom_range(0, 9))
         0, 1:    v = $urandom_range(0, 1) ? 255 : 0;
         2, 3, 4: v = $urandom_range(0, 255);
         // smooth areas give small gradients
         default: v = int'(last_pixel) + int'($urandom_range(0, 12)) - 6;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      last_pixel = v[PIX_W-1:0];
      return last_pixel;
   endfunction

   task automatic program_geometry(bit set_cols, logic [CFG_W-1:0] cols,
                                   bit set_rows, logic [CFG_W-1:0] rows);
      gm2x2_csr_idx_type idx;
      logic [CFG_W-1:0]  value;
      bit                wanted;
      for (int k = 0; k < 2; k++) begin
         if (k == 0) begin
            idx    = CSR_LINE_WIDTH;
            value  = cols;
            wanted = set_cols;
         end else begin
            idx    = CSR_FRAME_HEIGHT;
            value  = rows;
            wanted = set_rows;
         end
         if (wanted) begin
            csr_chan.valid <= 1'b1;
            csr_chan.index <= idx;
            csr_chan.data  <= value;
            @(posedge clock);
            while (!csr_chan.ready) @(posedge clock);
            edges.write_register(idx, value);
         end
      end
      csr_chan.valid <= 1'b0;
   endtask

   // valid stays high into the next call unless a gap is taken
   task automatic send_pixel(logic [PIX_W-1:0] pixel, logic frame_start);
      req_chan.valid       <= 1'b1;
      req_chan.pixel       <= pixel;
      req_chan.frame_start <= frame_start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      edges.note_pixel(pixel, frame_start);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_run(int count, bit restart, int restart_odds);
      logic fs;
      for (int n = 0; n < count; n++) begin
         fs = (n == 0 && restart) || edges.needs_restart() ||
              (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
         send_pixel(next_pixel(), fs);
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (edges.pending_edges.size() != 0) @(posedge clock);
      // pixels with no result may still sit in the front queue
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      static logic [PIX_W-1:0] opening [25] = '{
         8'd0, 8'd0, 8'd0, 8'd0,   8'd0, 8'd255, 8'd0, 8'd255,
         8'd255, 8'd0, 8'd0, 8'd255,   8'd10, 8'd0, 8'd0, 8'd0,
         8'd0, 8'd0, 8'd0, 8'd1,   8'd100, 8'd37, 8'd201, 8'd90, 8'd255
      };
      int               phase_pixels;
      int               sent;
      bit               set_cols;
      bit               set_rows;
      logic [CFG_W-1:0] cols;
      logic [CFG_W-1:0] rows;

      edges = new();
      calm       = 1'b0;
      last_pixel = '0;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.pixel       <= '0;
      req_chan.frame_start <= 1'b0;
      csr_chan.valid       <= 1'b0;
      csr_chan.index       <= CSR_LINE_WIDTH;
      csr_chan.data        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: a full first row and a few beats into the second
      send_run(int'(LINE_WIDTH_RST) + 10, 1'b1, 0);
      drain_results();

      // 2x2 frames: flat, saturating, cancelling, small and unit gradients,
      // frames that follow without a start and a start in mid frame
      program_geometry(1'b1, 12'd2, 1'b1, 12'd2);
      for (int n = 0; n < 25; n++)
         send_pixel(opening[n], n == 0 || n == 8 || n == 21);
      req_chan.valid <= 1'b0;
      drain_results();

      // zero height clamps to two
      program_geometry(1'b1, 12'd4, 1'b1, 12'd0);
      send_run(40, 1'b1, 0);
      drain_results();

      program_geometry(1'b1, 12'd3, 1'b1, 12'hFFF);
      send_run(90, 1'b1, 0);
      drain_results();

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         set_cols = $urandom_range(0, 9) < 7;
         case ($urandom_range(0, 19))
            0:       cols = CFG_W'($urandom_range(0, 1));
            1:       cols = CFG_W'($urandom_range(MAX_WIDTH + 1, 4095));
            2, 3:    cols = CFG_W'($urandom_range(17, 300));
            default: cols = CFG_W'($urandom_range(2, 16));
         endcase
         set_rows = $urandom_range(0, 9) < 6;
         case ($urandom_range(0, 11))
            0:       rows = CFG_W'($urandom_range(0, 1));
            1:       rows = CFG_W'($urandom_range(0, 1) ? 4095 : $urandom_range(9, 4094));
            default: rows = CFG_W'($urandom_range(2, 8));
         endcase
         // counts carry over, so a smaller geometry lands on a running frame
         program_geometry(set_cols, cols, set_rows, rows);
         calm = sent >= CALM_FROM || $urandom_range(0, 4) == 0;
         phase_pixels = $urandom_range(10, 120);
         send_run(phase_pixels, $urandom_range(0, 1) == 1, 50);
         sent += phase_pixels;
         drain_results();
      end

      if (edges.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
